FILE: src/jesc_pkg.sv
// ----------------------------------------------------------------------------
// jesc_pkg
// Shared types, constants and helpers of the Julia escape-time pixel unit.
// ----------------------------------------------------------------------------
`default_nettype none

package jesc_pkg;

  localparam int IMG_WIDTH_DEF  = 1024;
  localparam int IMG_HEIGHT_DEF = 1024;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int PIX_W      = 10;
  localparam int CNT_W      = 10;
  localparam int RGBA_W     = 32;
  localparam int Z_W        = 32;
  localparam int STEP_W     = 31;
  localparam int SQ_W       = 64;

  localparam logic [Z_W-1:0]    C_REAL_RST   = 32'hF3333333;
  localparam logic [Z_W-1:0]    C_IMAG_RST   = 32'h00000000;
  localparam logic [STEP_W-1:0] STEP_RST     = 31'd1048576;
  localparam logic [CNT_W-1:0]  MAX_ITER_RST = 10'd100;

  localparam int ESC_SHIFT = 58;
  localparam int RE_SHIFT  = 28;
  localparam int IM_SHIFT  = 27;

  localparam int          QW       = 8;
  localparam int          STEP_CW  = 3;
  localparam int          NUM_W    = 18;
  localparam int          DSH_W    = CNT_W + QW - 1;
  localparam logic [7:0]  ALPHA    = 8'hff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C_REAL     = 4'd0,
    REG_C_IMAG     = 4'd1,
    REG_PIXEL_STEP = 4'd2,
    REG_MAX_ITER   = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [Z_W-1:0]    c_real;
    logic [Z_W-1:0]    c_imag;
    logic [STEP_W-1:0] pixel_step;
    logic [CNT_W-1:0]  max_iter;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COORD,
    ST_MUL,
    ST_TEST,
    ST_SEG,
    ST_NUM,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic coord;
    logic mul;
    logic upd;
    logic seg;
    logic num;
    logic div;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic iter_go;
    logic div_last;
  } sts_t;

  function automatic logic [7:0] pal(input logic [1:0] row, input logic [1:0] col);
    logic [7:0] v;
    case ({row, col})
      4'b0000: v = 8'h73;
      4'b0001: v = 8'h03;
      4'b0010: v = 8'hc0;
      4'b0100: v = 8'hec;
      4'b0101: v = 8'h38;
      4'b0110: v = 8'hbc;
      4'b1000: v = 8'hfd;
      4'b1001: v = 8'hef;
      4'b1010: v = 8'hf9;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [Z_W-1:0] sat32(input logic signed [SQ_W-1:0] v);
    logic [Z_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = v[Z_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/jesc_ifs.sv
// ----------------------------------------------------------------------------
// jesc channel interfaces
// Valid/ready channels for pixel input, result output and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface jesc_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] pixel_x;
  logic [9:0] pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface jesc_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  iter_count;
  logic [31:0] pixel_rgba;
  modport source (output valid, iter_count, pixel_rgba, input ready);
  modport sink   (input valid, iter_count, pixel_rgba, output ready);
endinterface

interface jesc_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/jesc_regs.sv
// ----------------------------------------------------------------------------
// jesc_regs
// Configuration register file: Julia constant, pixel step, iteration limit.
// ----------------------------------------------------------------------------
`default_nettype none

module jesc_regs
  import jesc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_valid,
  output logic                       wr_ready,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign wr_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_valid) begin
      case (wr_index)
        REG_C_REAL:     cfg_nxt.c_real     = wr_data;
        REG_C_IMAG:     cfg_nxt.c_imag     = wr_data;
        REG_PIXEL_STEP: cfg_nxt.pixel_step = wr_data[STEP_W-1:0];
        REG_MAX_ITER:   cfg_nxt.max_iter   = wr_data[CNT_W-1:0];
        default:        cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c_real     <= C_REAL_RST;
      cfg_r.c_imag     <= C_IMAG_RST;
      cfg_r.pixel_step <= STEP_RST;
      cfg_r.max_iter   <= MAX_ITER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/jesc_datapath.sv
// ----------------------------------------------------------------------------
// jesc_datapath
// Start coordinate mapping, z = z*z + c iteration, escape test, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module jesc_datapath
  import jesc_pkg::*;
#(
  parameter int IMG_WIDTH  = IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = IMG_HEIGHT_DEF
)
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire cmd_t              cmd,
  input  wire logic [PIX_W-1:0]  pixel_x,
  input  wire logic [PIX_W-1:0]  pixel_y,
  input  wire logic [RGBA_W-1:0] rgba,
  output logic                   iter_go,
  output logic [CNT_W-1:0]       count,
  output logic [CNT_W-1:0]       out_iter_count,
  output logic [RGBA_W-1:0]      out_pixel_rgba
);

  localparam int SZ_MAX  = (IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;
  localparam int SZ_BITS = $clog2(SZ_MAX + 1);
  localparam int DW      = ((SZ_BITS > PIX_W + 1) ? SZ_BITS : PIX_W + 1) + 1;
  localparam int PW      = DW + STEP_W + 1;

  logic signed [DW-1:0]   dx;
  logic signed [DW-1:0]   dy;
  logic signed [Z_W-1:0]  step_s;
  logic signed [PW-1:0]   px_prod;
  logic signed [PW-1:0]   py_prod;
  logic signed [PW-1:0]   px_prod_r;
  logic signed [PW-1:0]   py_prod_r;
  logic signed [Z_W-1:0]  zr_r;
  logic signed [Z_W-1:0]  zi_r;
  logic signed [SQ_W-1:0] rr_r;
  logic signed [SQ_W-1:0] ii_r;
  logic signed [SQ_W-1:0] ri_r;
  logic signed [SQ_W-1:0] re_diff;
  logic signed [SQ_W-1:0] re_sum;
  logic signed [SQ_W-1:0] im_sum;
  logic [SQ_W-1:0]        mag;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       out_iter_count_r;
  logic [RGBA_W-1:0]      out_pixel_rgba_r;

  assign dx      = $signed(DW'({pixel_x, 1'b0})) - $signed(DW'(IMG_WIDTH));
  assign dy      = $signed(DW'({pixel_y, 1'b0})) - $signed(DW'(IMG_HEIGHT));
  assign step_s  = $signed({1'b0, cfg.pixel_step});
  assign px_prod = dx * step_s;
  assign py_prod = dy * step_s;

  assign re_diff = rr_r - ii_r;
  assign re_sum  = (re_diff >>> RE_SHIFT) + SQ_W'($signed(cfg.c_real));
  assign im_sum  = (ri_r >>> IM_SHIFT) + SQ_W'($signed(cfg.c_imag));
  assign mag     = $unsigned(rr_r) + $unsigned(ii_r);
  assign iter_go = (count_r < cfg.max_iter) && (mag[SQ_W-1:ESC_SHIFT] == '0);

  assign count          = count_r;
  assign out_iter_count = out_iter_count_r;
  assign out_pixel_rgba = out_pixel_rgba_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_prod_r <= px_prod;
      py_prod_r <= py_prod;
    end
    if (cmd.coord) begin
      zr_r    <= sat32(SQ_W'(px_prod_r >>> 1));
      zi_r    <= sat32(SQ_W'(py_prod_r >>> 1));
      count_r <= '0;
    end
    if (cmd.mul) begin
      rr_r <= zr_r * zr_r;
      ii_r <= zi_r * zi_r;
      ri_r <= zr_r * zi_r;
    end
    if (cmd.upd) begin
      zr_r    <= sat32(re_sum);
      zi_r    <= sat32(im_sum);
      count_r <= count_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_iter_count_r <= count_r;
      out_pixel_rgba_r <= rgba;
    end
  end

  a_upd_only_on_go: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> iter_go)
    else $error("iterate update without continue condition");

  a_upd_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |=> (count_r != '0))
    else $error("iteration count did not advance");

endmodule

`default_nettype wire

FILE: src/jesc_color.sv
// ----------------------------------------------------------------------------
// jesc_color
// Palette gradient: segment select, per-channel blend, 8-step restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module jesc_color
  import jesc_pkg::*;
(
  input  wire logic              clk,
  input  wire cmd_t              cmd,
  input  wire logic [CNT_W-1:0]  max_iter,
  input  wire logic [CNT_W-1:0]  count,
  output logic                   div_last,
  output logic [RGBA_W-1:0]      rgba
);

  logic [CNT_W-1:0]   d_nxt;
  logic [CNT_W-1:0]   r_nxt;
  logic               seg_nxt;
  logic [CNT_W-1:0]   cnt1;
  logic [CNT_W:0]     n;
  logic [CNT_W-1:0]   d_r;
  logic [CNT_W-1:0]   r_r;
  logic               seg_r;
  logic [1:0]         row_lo;
  logic [1:0]         row_hi;
  logic [NUM_W-1:0]   num [3];
  logic [NUM_W-1:0]   rem_r [3];
  logic [QW-1:0]      q_r [3];
  logic [DSH_W-1:0]   dsh_r;
  logic [STEP_CW-1:0] step_r;

  always_comb begin
    cnt1    = (count == '0) ? CNT_W'(1) : count;
    n       = {cnt1 - 1'b1, 1'b0};
    d_nxt   = CNT_W'(1);
    r_nxt   = '0;
    seg_nxt = 1'b0;
    if (max_iter > CNT_W'(1)) begin
      d_nxt = max_iter - 1'b1;
      if (n >= {1'b0, d_nxt}) begin
        seg_nxt = 1'b1;
        r_nxt   = CNT_W'(n - {1'b0, d_nxt});
      end else begin
        r_nxt   = n[CNT_W-1:0];
      end
    end
  end

  assign row_lo = {1'b0, seg_r};
  assign row_hi = row_lo + 2'd1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = NUM_W'(pal(row_lo, 2'(k))) * NUM_W'(d_r - r_r)
             + NUM_W'(pal(row_hi, 2'(k))) * NUM_W'(r_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seg) begin
      d_r   <= d_nxt;
      r_r   <= r_nxt;
      seg_r <= seg_nxt;
    end
    if (cmd.num) begin
      for (int k = 0; k < 3; k++) begin
        rem_r[k] <= num[k];
        q_r[k]   <= '0;
      end
      dsh_r  <= {d_r, {(QW-1){1'b0}}};
      step_r <= '0;
    end
    if (cmd.div) begin
      for (int k = 0; k < 3; k++) begin
        if (NUM_W'(dsh_r) <= rem_r[k]) begin
          rem_r[k] <= rem_r[k] - NUM_W'(dsh_r);
          q_r[k]   <= {q_r[k][QW-2:0], 1'b1};
        end else begin
          q_r[k]   <= {q_r[k][QW-2:0], 1'b0};
        end
      end
      dsh_r  <= dsh_r >> 1;
      step_r <= step_r + 1'b1;
    end
  end

  assign div_last = (step_r == STEP_CW'(QW - 1));
  assign rgba     = {q_r[0], q_r[1], q_r[2], ALPHA};

endmodule

`default_nettype wire

FILE: src/jesc_ctrl.sv
// ----------------------------------------------------------------------------
// jesc_ctrl
// Sequencer: coordinate map, iterate loop, colour divide, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module jesc_ctrl
  import jesc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_COORD;
      ST_COORD: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_TEST;
      ST_TEST:  state_nxt = sts.iter_go ? ST_MUL : ST_SEG;
      ST_SEG:   state_nxt = ST_NUM;
      ST_NUM:   state_nxt = ST_DIV;
      ST_DIV:   if (sts.div_last) state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_COORD: cmd.coord    = 1'b1;
      ST_MUL:   cmd.mul      = 1'b1;
      ST_TEST:  cmd.upd      = sts.iter_go;
      ST_SEG:   cmd.seg      = 1'b1;
      ST_NUM:   cmd.num      = 1'b1;
      ST_DIV:   cmd.div      = 1'b1;
      ST_OUT:   cmd.out_load = out_free;
      default:  cmd          = '0;
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_to_coord: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_COORD))
    else $error("accepted transaction did not start coordinate mapping");

  a_div_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && sts.div_last) |=> (state_r == ST_OUT))
    else $error("divide finish did not reach result handoff");

  a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result valid raised outside handoff state");

endmodule

`default_nettype wire

FILE: src/julia_escape_time_pixel_unit.sv
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_unit
// Julia-set escape-time count and gradient colour for one pixel coordinate.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                          Transaction
// in_ch     in   pixel_x[9:0], pixel_y[9:0]       valid && ready
// out_ch    out  iter_count[9:0], pixel_rgba[31:0] valid && ready
// cfg_ch    in   index[3:0], data[31:0]           valid && ready (always ready)
//
// One pixel at a time: each iteration passes the multiply state (ST_MUL)
// and then the escape-test/update state (ST_TEST) on the shared iterate
// unit; the colour divide follows the loop. Reset loads the register defaults.
// A stalled result sits in the output register; the next input transaction
// is taken meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module julia_escape_time_pixel_unit
  import jesc_pkg::*;
#(
  parameter int IMG_WIDTH  = IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = IMG_HEIGHT_DEF
)
(
  input  wire logic clk,
  input  wire logic rst_n,
  jesc_in_if.sink   in_ch,
  jesc_out_if.source out_ch,
  jesc_cfg_if.sink  cfg_ch
);

  cfg_t              cfg;
  cmd_t              cmd;
  sts_t              sts;
  logic              iter_go;
  logic              div_last;
  logic [CNT_W-1:0]  count;
  logic [RGBA_W-1:0] rgba;

  assign sts.iter_go  = iter_go;
  assign sts.div_last = div_last;

  jesc_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_ch.valid),
    .wr_ready (cfg_ch.ready),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  jesc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  jesc_datapath #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .pixel_x        (in_ch.pixel_x),
    .pixel_y        (in_ch.pixel_y),
    .rgba           (rgba),
    .iter_go        (iter_go),
    .count          (count),
    .out_iter_count (out_ch.iter_count),
    .out_pixel_rgba (out_ch.pixel_rgba)
  );

  jesc_color u_color (
    .clk      (clk),
    .cmd      (cmd),
    .max_iter (cfg.max_iter),
    .count    (count),
    .div_last (div_last),
    .rgba     (rgba)
  );

endmodule

`default_nettype wire

FILE: dv/julia_escape_time_pixel_unit_tb.sv
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_unit_tb
// Drives pixel coordinates through the Julia escape-time unit under several
// register settings and handshake idling patterns. A scoreboard predicts the
// iteration count and gradient colour of each pixel in exact Q4.28 integer
// arithmetic and checks every result transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none

import jesc_pkg::*;

localparam logic [71:0]           JULIA_GRADIENT = 72'h7303c0_ec38bc_fdeff9;
localparam longint unsigned       ESCAPE_SQ      = 64'h0400_0000_0000_0000;
localparam longint                Q_MAX          = 64'sd2147483647;
localparam longint                Q_MIN          = -64'sd2147483648;

class julia_pixel_sb;
  typedef struct {
    logic [9:0]  count;
    logic [31:0] rgba;
  } pixel_result_t;

  int          c_re;
  int          c_im;
  int unsigned step;
  int unsigned lim;
  int          errors;
  pixel_result_t pending[$];

  function new();
    c_re   = -214748365;
    c_im   = 0;
    step   = 1048576;
    lim    = 100;
    errors = 0;
  endfunction

  function void write_reg(logic [3:0] idx, logic [31:0] data);
    case (idx)
      REG_C_REAL:     c_re = int'(data);
      REG_C_IMAG:     c_im = int'(data);
      REG_PIXEL_STEP: step = {1'b0, data[30:0]};
      REG_MAX_ITER:   lim  = {22'd0, data[9:0]};
      default: ;
    endcase
  endfunction

  function int clamp_q(longint v);
    if (v > Q_MAX) begin
      return int'(Q_MAX);
    end
    if (v < Q_MIN) begin
      return int'(Q_MIN);
    end
    return int'(v);
  endfunction

  function int start_point(logic [9:0] p, int size);
    longint d;
    d = 2 * longint'(p) - longint'(size);
    return clamp_q((d * longint'(step)) >>> 1);
  endfunction

  function logic [31:0] shade(int unsigned n);
    int unsigned d, k, seg, r, a, b;
    int          i;
    logic [31:0] rgba;
    if (lim <= 1) begin
      seg = 0;
      d   = 1;
      r   = 0;
    end else begin
      d   = lim - 1;
      k   = (n < 1) ? 0 : 2 * (n - 1);
      seg = k / d;
      if (seg > 1) begin
        seg = 1;
      end
      r = k - seg * d;
    end
    rgba       = '0;
    rgba[7:0]  = 8'hff;
    for (i = 0; i < 3; i++) begin
      a = JULIA_GRADIENT[71 - 24 * seg - 8 * i -: 8];
      b = JULIA_GRADIENT[47 - 24 * seg - 8 * i -: 8];
      rgba[31 - 8 * i -: 8] = 8'((a * (d - r) + b * r) / d);
    end
    return rgba;
  endfunction

  function pixel_result_t escape_pixel(logic [9:0] x, logic [9:0] y);
    pixel_result_t res;
    int            zr, zi, nr;
    longint        rr, ii, ri;
    int unsigned   n;
    zr = start_point(x, IMG_WIDTH_DEF);
    zi = start_point(y, IMG_HEIGHT_DEF);
    n  = 0;
    while (n < lim) begin
      rr = longint'(zr) * longint'(zr);
      ii = longint'(zi) * longint'(zi);
      if ($unsigned(rr) + $unsigned(ii) >= ESCAPE_SQ) begin
        break;
      end
      ri = longint'(zr) * longint'(zi);
      nr = clamp_q(((rr - ii) >>> 28) + longint'(c_re));
      zi = clamp_q((ri >>> 27) + longint'(c_im));
      zr = nr;
      n++;
    end
    res.count = n[9:0];
    res.rgba  = shade(n);
    return res;
  endfunction

  function void note_pixel(logic [9:0] x, logic [9:0] y);
    pending.push_back(escape_pixel(x, y));
  endfunction

  function void check_pixel(realtime at_ns, logic [9:0] cnt, logic [31:0] rgba);
    pixel_result_t want;
    if (pending.size() == 0) begin
      errors++;
      $display("%0.1f ns: unexpected result, iter_count %0d pixel_rgba %08h",
               at_ns, cnt, rgba);
      return;
    end
    want = pending.pop_front();
    if (cnt !== want.count) begin
      errors++;
      $display("%0.1f ns: iter_count expected %0d actual %0d", at_ns, want.count, cnt);
    end
    if (rgba !== want.rgba) begin
      errors++;
      $display("%0.1f ns: pixel_rgba expected %08h actual %08h", at_ns, want.rgba, rgba);
    end
  endfunction
endclass

module julia_escape_time_pixel_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT = 2000000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic clk;
  logic rst_n;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   cycles    = 0;

  jesc_in_if  pix_ch ();
  jesc_out_if res_ch ();
  jesc_cfg_if cfg_ch ();

  julia_pixel_sb sb = new();

  julia_escape_time_pixel_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix_ch),
    .out_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      sb.write_reg(cfg_ch.index, cfg_ch.data);
    end
    if (rst_n && pix_ch.valid && pix_ch.ready) begin
      sb.note_pixel(pix_ch.pixel_x, pix_ch.pixel_y);
    end
    if (rst_n && res_ch.valid && res_ch.ready) begin
      sb.check_pixel($realtime, res_ch.iter_count, res_ch.pixel_rgba);
    end
  end

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic void set_idling(idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        idle_pct  = 81;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        idle_pct  = 0;
        stall_pct = 81;
      end
      IDLE_BOTH: begin
        idle_pct  = 7;
        stall_pct = 7;
      end
      default: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
    endcase
  endfunction

  // leaves valid high; the caller lowers it after the last write
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic load_view(input logic [31:0] cr, input logic [31:0] ci,
                           input logic [30:0] st, input logic [9:0] mi);
    logic [31:0] st_word;
    logic [31:0] mi_word;
    st_word       = $urandom();
    st_word[30:0] = st;
    mi_word       = $urandom();
    mi_word[9:0]  = mi;
    write_reg(REG_C_REAL, cr);
    write_reg(REG_C_IMAG, ci);
    // unmapped index, must be ignored
    write_reg(cfg_reg_t'(4'($urandom_range(4, 15))), $urandom());
    write_reg(REG_PIXEL_STEP, st_word);
    write_reg(REG_MAX_ITER, mi_word);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [9:0] x, input logic [9:0] y);
    while ($urandom_range(0, 99) < idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid   <= 1'b1;
    pix_ch.pixel_x <= x;
    pix_ch.pixel_y <= y;
    do @(posedge clk); while (!pix_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    pix_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_phase(input int p);
    logic [31:0] cr;
    logic [31:0] ci;
    logic [30:0] st;
    logic [9:0]  mi;
    if (p % 3 == 2) begin
      cr = $urandom();
      ci = $urandom();
    end else begin
      cr = 32'($urandom_range(0, 536870912)) - 32'd268435456;
      ci = 32'($urandom_range(0, 536870912)) - 32'd268435456;
    end
    st = ($urandom_range(0, 4) == 0) ? 31'($urandom()) :
                                       31'($urandom_range(262144, 2097152));
    mi = (p == 5) ? 10'd1023 : 10'($urandom_range(2, 120));
    set_idling(idle_mode_t'(p % 4));
    load_view(cr, ci, st, mi);
    repeat (48) begin
      send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    end
    drain();
  endtask

  initial begin
    int p;
    rst_n          = 1'b0;
    pix_ch.valid   = 1'b0;
    pix_ch.pixel_x = '0;
    pix_ch.pixel_y = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_C_REAL;
    cfg_ch.data    = '0;
    set_idling(IDLE_NONE);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: corners, center, left edge at exactly -2 escapes at once
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd512);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd512, 10'd1023);
    send_pixel(10'd767, 10'd384);
    send_pixel(10'd300, 10'd700);
    drain();

    // zero step, top iteration limit
    load_view(32'hF3333333, 32'h0, 31'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd345, 10'd678);
    drain();

    // coordinate saturation, zero limit
    load_view(32'h7fffffff, 32'h80000000, 31'h7fffffff, 10'd0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd512);
    drain();

    // smallest step, limit of one
    load_view(32'h80000000, 32'h7fffffff, 31'd1, 10'd1);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd513, 10'd511);
    send_pixel(10'd0, 10'd1023);
    drain();

    // iterate saturation in both directions
    load_view(32'h7fffffff, 32'h80000000, 31'd1048576, 10'd2);
    send_pixel(10'd896, 10'd512);
    send_pixel(10'd512, 10'd896);
    send_pixel(10'd900, 10'd900);
    drain();
    load_view(32'h80000000, 32'h7fffffff, 31'd1048576, 10'd2);
    send_pixel(10'd512, 10'd896);
    send_pixel(10'd896, 10'd896);
    send_pixel(10'd128, 10'd640);
    drain();

    for (p = 0; p < 8; p++) begin
      random_phase(p);
    end

    repeat (64) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

`default_nettype wire
